FILE: rtl/rau_pkg.sv
// shared types and codes for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [FIELD_BITS-1:0] a_num;
    logic signed [FIELD_BITS-1:0] a_den;
    logic signed [FIELD_BITS-1:0] b_num;
    logic signed [FIELD_BITS-1:0] b_den;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_num;
    logic signed [FIELD_BITS-1:0] res_den;
    logic                         div_by_zero;
  } out_req_t;

  // datapath operation selects
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_MUL0   = 4'd2,
    OP_MUL1   = 4'd3,
    OP_MUL2   = 4'd4,
    OP_COMB   = 4'd5,
    OP_GCDINI = 4'd6,
    OP_DIVSTR = 4'd7,
    OP_DIVSTP = 4'd8,
    OP_GCDNXT = 4'd9,
    OP_QNUM   = 4'd10,
    OP_QDEN   = 4'd11,
    OP_FIX    = 4'd12
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_sel;  // 0: euclid remainder, 1: quotient by gcd
  } cmd_t;

  typedef struct packed {
    logic is_addsub;
    logic is_mul;
    logic is_div_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/rau_datapath.sv
// datapath: multiplier, shift-subtract divider and result registers
module rau_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::in_req_t  in_req,
  input  rau_pkg::cmd_t     cmd,
  output rau_pkg::sts_t     sts,
  output rau_pkg::out_req_t res
);

  localparam int unsigned CW = $clog2(WORD_BITS + 1);
  localparam int unsigned FB = rau_pkg::FIELD_BITS;

  logic [1:0]           kind_r, kind_nxt;
  logic [WORD_BITS-1:0] an_r, ad_r, bn_r, bd_r;
  logic [WORD_BITS-1:0] an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic [WORD_BITS-1:0] p_r, q_r, p_nxt, q_nxt;
  logic [WORD_BITS-1:0] rn_r, rd_r, rn_nxt, rd_nxt;
  logic [WORD_BITS-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [WORD_BITS-1:0] dq_r, drem_r, dvs_r, dq_nxt, drem_nxt, dvs_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 err_r, err_nxt;

  logic [WORD_BITS-1:0] m_a, m_b, m_p;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   rem_sh;

  function automatic logic [WORD_BITS-1:0] rd_word(input logic [FB-1:0] f);
    logic [WORD_BITS+FB-1:0] e;
    e = {{WORD_BITS{f[FB-1]}}, f};
    return e[WORD_BITS-1:0];
  endfunction

  function automatic logic [FB-1:0] wr_word(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS+FB-1:0] e;
    e = {{FB{w[WORD_BITS-1]}}, w};
    return e[FB-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // one shared multiplier, operands chosen by the step
  always_comb begin
    m_a = an_r;
    m_b = bn_r;
    case (cmd.op)
      rau_pkg::OP_MUL0: begin
        m_a = bd_r;
        m_b = (kind_r == rau_pkg::KIND_DIV) ? an_r : an_r;
        if (kind_r == rau_pkg::KIND_MUL) begin
          m_a = an_r;
          m_b = bn_r;
        end
      end
      rau_pkg::OP_MUL1: begin
        m_a = ad_r;
        m_b = bn_r;
      end
      rau_pkg::OP_MUL2: begin
        m_a = ad_r;
        m_b = bd_r;
      end
      default: begin
        m_a = an_r;
        m_b = bn_r;
      end
    endcase
  end

  assign m_p    = m_a * m_b;
  assign rem_sh = {drem_r, dq_r[WORD_BITS-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_comb begin
    kind_nxt = kind_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    p_nxt = p_r; q_nxt = q_r;
    rn_nxt = rn_r; rd_nxt = rd_r;
    x_nxt = x_r; y_nxt = y_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    case (cmd.op)
      rau_pkg::OP_LOAD: begin
        kind_nxt = in_req.kind;
        an_nxt = rd_word(in_req.a_num);
        ad_nxt = rd_word(in_req.a_den);
        bn_nxt = rd_word(in_req.b_num);
        bd_nxt = rd_word(in_req.b_den);
        err_nxt = 1'b0;
      end
      rau_pkg::OP_MUL0: p_nxt = m_p;
      rau_pkg::OP_MUL1: q_nxt = m_p;
      rau_pkg::OP_MUL2: rd_nxt = m_p;
      rau_pkg::OP_COMB: begin
        case (kind_r)
          rau_pkg::KIND_ADD: begin
            if (ad_r == bd_r) begin
              rn_nxt = an_r + bn_r;
              rd_nxt = ad_r;
            end else begin
              rn_nxt = p_r + q_r;
            end
          end
          rau_pkg::KIND_SUB: begin
            if (ad_r == bd_r) begin
              rn_nxt = an_r - bn_r;
              rd_nxt = ad_r;
            end else begin
              rn_nxt = p_r - q_r;
            end
          end
          rau_pkg::KIND_MUL: rn_nxt = p_r;
          default: begin
            if (bn_r == '0) begin
              err_nxt = 1'b1;
              rn_nxt  = '0;
              rd_nxt  = '0;
            end else begin
              rn_nxt = p_r;
              rd_nxt = q_r;
            end
          end
        endcase
        // a zero sum or difference reduces to 0/1
        if ((kind_r == rau_pkg::KIND_ADD || kind_r == rau_pkg::KIND_SUB) &&
            rn_nxt == '0) begin
          rd_nxt = WORD_BITS'(1);
        end
      end
      rau_pkg::OP_GCDINI: begin
        x_nxt = mag(rn_r);
        y_nxt = mag(rd_r);
      end
      rau_pkg::OP_DIVSTR: begin
        dq_nxt   = cmd.div_sel ? x_r : x_r;
        dvs_nxt  = cmd.div_sel ? x_r : y_r;
        drem_nxt = '0;
        cnt_nxt  = CW'(WORD_BITS);
        if (!cmd.div_sel) dq_nxt = x_r;
      end
      rau_pkg::OP_DIVSTP: begin
        if (!trial[WORD_BITS]) begin
          drem_nxt = trial[WORD_BITS-1:0];
          dq_nxt   = {dq_r[WORD_BITS-2:0], 1'b1};
        end else begin
          drem_nxt = rem_sh[WORD_BITS-1:0];
          dq_nxt   = {dq_r[WORD_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      rau_pkg::OP_GCDNXT: begin
        x_nxt = y_r;
        y_nxt = drem_r;
      end
      default: ;
    endcase
    // quotient steps reuse divider with dividend loaded separately
    if (cmd.op == rau_pkg::OP_QNUM) begin
      dq_nxt   = mag(rn_r);
      dvs_nxt  = x_r;
      drem_nxt = '0;
      cnt_nxt  = CW'(WORD_BITS);
    end
    if (cmd.op == rau_pkg::OP_QDEN) begin
      rn_nxt   = rn_r[WORD_BITS-1] ? (~dq_r + 1'b1) : dq_r;
      dq_nxt   = mag(rd_r);
      dvs_nxt  = x_r;
      drem_nxt = '0;
      cnt_nxt  = CW'(WORD_BITS);
    end
    if (cmd.op == rau_pkg::OP_FIX) begin
      if (rd_r[WORD_BITS-1]) begin
        // signs: a negative den moves its sign to the numerator; net den = |q|
        rd_nxt = dq_r;
        rn_nxt = ~rn_r + 1'b1;
      end else begin
        rd_nxt = dq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
    kind_r <= kind_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    p_r <= p_nxt; q_r <= q_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt;
    x_r <= x_nxt; y_r <= y_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dvs_r <= dvs_nxt;
  end

  assign sts.is_addsub  = (kind_r == rau_pkg::KIND_ADD) || (kind_r == rau_pkg::KIND_SUB);
  assign sts.is_mul     = (kind_r == rau_pkg::KIND_MUL);
  assign sts.is_div_zero = err_r;
  assign sts.num_zero   = (rn_r == '0);
  assign sts.gcd_done   = (y_r == '0);
  assign sts.div_done   = (cnt_r == '0);

  assign res.res_num     = wr_word(rn_r);
  assign res.res_den     = wr_word(rd_r);
  assign res.div_by_zero = err_r;

endmodule

FILE: rtl/rau_ctrl.sv
// controller: sequences load, products, euclid loop and reduction
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd,
  output logic          res_load
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_MUL0  = 14'b00000000000010,
    S_MUL1  = 14'b00000000000100,
    S_MUL2  = 14'b00000000001000,
    S_COMB  = 14'b00000000010000,
    S_CHK   = 14'b00000000100000,
    S_GINI  = 14'b00000001000000,
    S_GTST  = 14'b00000010000000,
    S_GDIV  = 14'b00000100000000,
    S_QNUM  = 14'b00001000000000,
    S_QNDIV = 14'b00010000000000,
    S_QDDIV = 14'b00100000000000,
    S_FIX   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt   = state_r;
    ov_nxt      = ov_r;
    cmd.op      = rau_pkg::OP_NONE;
    cmd.div_sel = 1'b0;
    res_load    = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.op = rau_pkg::OP_LOAD;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.op = rau_pkg::OP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op = rau_pkg::OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op = rau_pkg::OP_MUL2;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.op = rau_pkg::OP_COMB;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!sts.is_addsub) state_nxt = S_DONE;
        else if (sts.num_zero) state_nxt = S_DONE;
        else state_nxt = S_GINI;
      end
      S_GINI: begin
        cmd.op = rau_pkg::OP_GCDINI;
        state_nxt = S_GTST;
      end
      S_GTST: begin
        if (sts.gcd_done) begin
          state_nxt = S_QNUM;
        end else begin
          cmd.op = rau_pkg::OP_DIVSTR;
          state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        if (sts.div_done) begin
          cmd.op = rau_pkg::OP_GCDNXT;
          state_nxt = S_GTST;
        end else begin
          cmd.op = rau_pkg::OP_DIVSTP;
        end
      end
      S_QNUM: begin
        cmd.op = rau_pkg::OP_QNUM;
        state_nxt = S_QNDIV;
      end
      S_QNDIV: begin
        if (sts.div_done) begin
          cmd.op = rau_pkg::OP_QDEN;
          state_nxt = S_QDDIV;
        end else begin
          cmd.op = rau_pkg::OP_DIVSTP;
        end
      end
      S_QDDIV: begin
        if (sts.div_done) state_nxt = S_FIX;
        else cmd.op = rau_pkg::OP_DIVSTP;
      end
      S_FIX: begin
        cmd.op = rau_pkg::OP_FIX;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

FILE: rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
//
// input channel in_valid/in_ready carries one request: kind, a_num/a_den,
// b_num/b_den. the result channel out_valid/out_ready carries res_num,
// res_den and div_by_zero, one result request per input request
// multiply and divide raise out_valid after three steps on one shared
// multiplier plus combine, check and handoff
// add and subtract also reduce by the euclid gcd; each remainder is a
// WORD_BITS-step shift-subtract divide, repeated per euclid step (up to
// ~46 steps), followed by two final quotients that divide numerator and
// denominator by the gcd
// one item is in flight at a time; the result register is held until
// taken, and a new request is taken only once the held result has left
// when the receiver stalls the result simply waits in its register
// synchronous active-low reset returns the controller to idle and
// drops out_valid; of the datapath only the divide count and error flag are cleared
// magnitudes are unsigned, so the most negative word is handled as 2^(W-1)
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rau_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output rau_pkg::out_req_t out_req
);

  rau_pkg::cmd_t     cmd;
  rau_pkg::sts_t     sts;
  rau_pkg::out_req_t dp_res;
  rau_pkg::out_req_t out_r;
  logic              res_load;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd),
    .res_load (res_load)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cmd    (cmd),
    .sts    (sts),
    .res    (dp_res)
  );

  // output register holds the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (res_load) out_r <= dp_res;
  end

  assign out_req = out_r;

endmodule

FILE: rtl/rau_checker.sv
// port-level checks for the rational arithmetic unit
module rau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rau_pkg::out_req_t out_req
);

  // a held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("result changed while stalled");

  // no new request while a result is waiting
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken with result pending");

  // accepted request cannot produce a result in the next cycle
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.div_by_zero |-> out_req.res_num == 0 && out_req.res_den == 0)
    else $error("divide error with nonzero fields");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_req  (out_req)
);
